@@ rtl/mocad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mocad_pkg: shared types and constants
// Register indexes, reset values, per-axis state and the configuration bundle
// for the magnetometer offset calibration and detect unit.
// ----------------------------------------------------------------------------
package mocad_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_SETTLE_TICKS       = 3'd0,
      CSR_BUSY_SETTLE_LEVEL  = 3'd1,
      CSR_OFF_LOW            = 3'd2,
      CSR_OFF_HIGH           = 3'd3,
      CSR_POT_MID            = 3'd4,
      CSR_OFF_RANGE_LIMIT    = 3'd5,
      CSR_AVG_SKIP_INTERVAL  = 3'd6,
      CSR_USE_Y_IN_MAGNITUDE = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_BITS = 10;

   // Reset values
   localparam logic [9:0] SETTLE_TICKS_RST      = 10'd160;
   localparam logic [9:0] BUSY_SETTLE_LEVEL_RST = 10'd100;
   localparam logic [9:0] OFF_LOW_RST           = 10'd300;
   localparam logic [9:0] OFF_HIGH_RST          = 10'd700;
   localparam logic [9:0] POT_MID_RST           = 10'd500;
   localparam logic [3:0] OFF_RANGE_LIMIT_RST   = 4'd1;
   localparam logic [7:0] AVG_SKIP_INTERVAL_RST = 8'd0;
   localparam logic       USE_Y_RST             = 1'b0;
   localparam logic [7:0] POT_RST               = 8'd128;

   // Arithmetic constants
   localparam logic [15:0] RELOAD_OFFSET  = 16'hEB;
   localparam logic [14:0] SCOPE_GAIN     = 15'd70;
   localparam logic [6:0]  DEV_CLIP       = 7'd127;
   localparam logic [2:0]  MAG_HOLD_TICKS = 3'd4;
   // Off-range count saturates just above the largest limit; compares are unchanged
   localparam logic [4:0]  OFF_COUNT_SAT  = 5'd16;

   typedef struct packed {
      logic [9:0] busy_settle_level;
      logic [9:0] off_low;
      logic [9:0] off_high;
      logic [9:0] pot_mid;
      logic [3:0] off_range_limit;
      logic [7:0] avg_skip_interval;
      logic       use_y_in_magnitude;
   } cfg_type;

   typedef struct packed {
      logic [15:0] baseline;
      logic [15:0] fast_avg;
      logic [4:0]  off_count;
      logic [7:0]  pot;
      logic        pot_changed;
   } axis_state_type;

   // Tick-wide control shared by both axes
   typedef struct packed {
      logic settling;     // settle count nonzero after this tick's decrement
      logic busy;         // settle count above busy level
      logic base_update;  // baseline average runs this tick
   } axis_ctrl_type;

   typedef struct packed {
      logic [14:0] scope;
      logic        pot_write;
   } axis_out_type;

endpackage
`default_nettype wire

@@ rtl/mocad_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mocad_axis: per-axis next-state logic
// Baseline and fast averages, baseline reload after a pot step, off-range
// counter, pot stepping and the scope value for one axis.
// ----------------------------------------------------------------------------
module mocad_axis #(
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  logic [SAMPLE_BITS-1:0]    sample,
   input  mocad_pkg::axis_ctrl_type  ctrl,
   input  mocad_pkg::cfg_type        cfg,
   input  mocad_pkg::axis_state_type state_cur,
   output mocad_pkg::axis_state_type state_next,
   output mocad_pkg::axis_out_type   result
);

   logic [15:0] s16;
   logic [15:0] base_avg;
   logic [15:0] base_reload;
   logic        off_range;
   logic [4:0]  count_next;
   logic        step;
   logic        raise;
   logic [7:0]  pot_next;

   assign s16 = 16'(sample);

   always_comb begin
      if (ctrl.base_update) begin
         base_avg = state_cur.baseline - (state_cur.baseline >> 5) + (s16 >> 3);
      end else begin
         base_avg = state_cur.baseline;
      end
   end

   // wraps as two's complement for samples below the offset
   assign base_reload = (s16 - mocad_pkg::RELOAD_OFFSET) << 2;

   assign off_range = (s16 > 16'(cfg.off_high)) || (s16 < 16'(cfg.off_low)) || ctrl.busy;

   always_comb begin
      if (!off_range) begin
         count_next = '0;
      end else if (state_cur.off_count == mocad_pkg::OFF_COUNT_SAT) begin
         count_next = state_cur.off_count;
      end else begin
         count_next = state_cur.off_count + 5'd1;
      end
   end

   assign step  = (count_next > 5'(cfg.off_range_limit)) || (ctrl.settling && count_next > 5'd1);
   assign raise = s16 > 16'(cfg.pot_mid);

   always_comb begin
      pot_next = state_cur.pot;
      if (step) begin
         if (raise) begin
            if (state_cur.pot != 8'hFF) pot_next = state_cur.pot + 8'd1;
         end else begin
            if (state_cur.pot != 8'h00) pot_next = state_cur.pot - 8'd1;
         end
      end
   end

   always_comb begin
      state_next.fast_avg    = state_cur.fast_avg - (state_cur.fast_avg >> 2) + (s16 << 1);
      state_next.baseline    = state_cur.pot_changed ? base_reload : base_avg;
      state_next.off_count   = count_next;
      state_next.pot         = pot_next;
      state_next.pot_changed = step;
   end

   // scope uses the pot before this tick's step
   assign result.scope = 15'(state_cur.pot) * mocad_pkg::SCOPE_GAIN + 15'(sample >> 1);
   assign result.pot_write = step;

endmodule
`default_nettype wire

@@ rtl/mocad_mag.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mocad_mag: event magnitude
// Clipped deviation of baseline from fast average per axis, squared and summed.
// ----------------------------------------------------------------------------
module mocad_mag (
   input  logic [15:0] x_baseline,
   input  logic [15:0] x_fast_avg,
   input  logic [15:0] y_baseline,
   input  logic [15:0] y_fast_avg,
   input  logic        use_y,
   input  logic        mag_valid,
   output logic [14:0] magnitude
);

   // |floor(d/4)| clipped, d = base/4 - fast/8
   function automatic logic [6:0] clip_dev(input logic [15:0] base, input logic [15:0] fast);
      logic signed [15:0] d;
      logic [14:0]        a;
      logic [12:0]        q;
      d = $signed({2'b00, base[15:2]}) - $signed({3'b000, fast[15:3]});
      if (!d[15]) begin
         a = d[14:0];
      end else begin
         a = 15'(-d) + 15'd3;
      end
      q = a[14:2];
      if (q > 13'(mocad_pkg::DEV_CLIP)) begin
         return mocad_pkg::DEV_CLIP;
      end
      return q[6:0];
   endfunction

   logic [6:0]  x_dev;
   logic [6:0]  y_dev;
   logic [13:0] x_sq;
   logic [13:0] y_sq;

   assign x_dev = clip_dev(x_baseline, x_fast_avg);
   assign y_dev = use_y ? clip_dev(y_baseline, y_fast_avg) : 7'd0;
   assign x_sq  = 14'(x_dev) * 14'(x_dev);
   assign y_sq  = 14'(y_dev) * 14'(y_dev);

   assign magnitude = mag_valid ? (15'(x_sq) + 15'(y_sq)) : 15'd0;

endmodule
`default_nettype wire

@@ rtl/magnetometer_offset_autocal_detect_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted item moves through the input, tick-result and output registers to rsp.
// Throughput: one item per cycle unless rsp_stall holds the pipeline; the state update
//   of a tick (counters and both axis updates) is combinational; ticks run back to back.
// Reset: synchronous; settle count loads 160, averages and counters clear, pots go
//   to 128, config and valid bits reset; data registers do not. No clearing pass.
// ----------------------------------------------------------------------------
// magnetometer_offset_autocal_detect_unit: offset auto-calibration and detect
// Three register stages: input register, state update with result capture,
// magnitude and output register. Each stage holds while the next one is full
// and stalled.
// ----------------------------------------------------------------------------
module magnetometer_offset_autocal_detect_unit #(
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_x_sample,
   input  logic [SAMPLE_BITS-1:0] req_y_sample,
   // item out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_pot_x_value,
   output logic [7:0]             rsp_pot_y_value,
   output logic                   rsp_pot_x_write,
   output logic                   rsp_pot_y_write,
   output logic [14:0]            rsp_scope_x,
   output logic [14:0]            rsp_scope_y,
   output logic [14:0]            rsp_magnitude,
   output logic                   rsp_magnitude_valid,
   // configuration
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [mocad_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   // ---------------- configuration ----------------
   // settle_ticks is accepted but has no live effect: reset always loads the settle
   // count from its fixed default.
   mocad_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.busy_settle_level  <= mocad_pkg::BUSY_SETTLE_LEVEL_RST;
         cfg_ff.off_low            <= mocad_pkg::OFF_LOW_RST;
         cfg_ff.off_high           <= mocad_pkg::OFF_HIGH_RST;
         cfg_ff.pot_mid            <= mocad_pkg::POT_MID_RST;
         cfg_ff.off_range_limit    <= mocad_pkg::OFF_RANGE_LIMIT_RST;
         cfg_ff.avg_skip_interval  <= mocad_pkg::AVG_SKIP_INTERVAL_RST;
         cfg_ff.use_y_in_magnitude <= mocad_pkg::USE_Y_RST;
      end else if (csr_write_en) begin
         case (mocad_pkg::csr_index_type'(csr_index))
            mocad_pkg::CSR_BUSY_SETTLE_LEVEL:  cfg_ff.busy_settle_level  <= csr_write_data;
            mocad_pkg::CSR_OFF_LOW:            cfg_ff.off_low            <= csr_write_data;
            mocad_pkg::CSR_OFF_HIGH:           cfg_ff.off_high           <= csr_write_data;
            mocad_pkg::CSR_POT_MID:            cfg_ff.pot_mid            <= csr_write_data;
            mocad_pkg::CSR_OFF_RANGE_LIMIT:    cfg_ff.off_range_limit    <= csr_write_data[3:0];
            mocad_pkg::CSR_AVG_SKIP_INTERVAL:  cfg_ff.avg_skip_interval  <= csr_write_data[7:0];
            mocad_pkg::CSR_USE_Y_IN_MAGNITUDE: cfg_ff.use_y_in_magnitude <= csr_write_data[0];
            default: ;  // settle_ticks: nothing to update
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic a_valid_ff;
   logic b_valid_ff;
   logic rsp_valid_ff;
   logic c_ready;
   logic b_ready;
   logic a_ready;
   logic a_fire;
   logic b_fire;

   assign c_ready   = !rsp_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_fire    = a_valid_ff && b_ready;  // tick is processed, state updates
   assign b_fire    = b_valid_ff && c_ready;
   assign req_stall = !a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready)  a_valid_ff   <= req_valid;
         if (b_ready)  b_valid_ff   <= a_valid_ff;
         if (c_ready)  rsp_valid_ff <= b_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage A: input register ----------------
   logic [SAMPLE_BITS-1:0] a_x_ff;
   logic [SAMPLE_BITS-1:0] a_y_ff;

   always_ff @(posedge clock) begin
      if (req_valid && a_ready) begin
         a_x_ff <= req_x_sample;
         a_y_ff <= req_y_sample;
      end
   end

   // ---------------- tick state ----------------
   logic [9:0] settle_count_ff;
   logic [9:0] settle_count_in;
   logic [7:0] avg_skip_count_ff;
   logic [7:0] avg_skip_count_in;
   logic [2:0] mag_hold_count_ff;
   logic [2:0] mag_hold_count_in;
   logic       mag_valid_in;

   mocad_pkg::axis_state_type x_state_ff;
   mocad_pkg::axis_state_type y_state_ff;
   mocad_pkg::axis_state_type x_state_in;
   mocad_pkg::axis_state_type y_state_in;
   mocad_pkg::axis_ctrl_type  axis_ctrl;
   mocad_pkg::axis_out_type   x_out;
   mocad_pkg::axis_out_type   y_out;

   // Settle counts down first; everything after sees the decremented value.
   assign settle_count_in = (settle_count_ff == 10'd0) ? 10'd0 : settle_count_ff - 10'd1;

   assign axis_ctrl.settling    = settle_count_in != 10'd0;
   assign axis_ctrl.busy        = settle_count_in > cfg_ff.busy_settle_level;
   assign axis_ctrl.base_update = axis_ctrl.settling || (avg_skip_count_ff == 8'd0);

   assign avg_skip_count_in = axis_ctrl.base_update ? cfg_ff.avg_skip_interval
                                                    : avg_skip_count_ff - 8'd1;

   // Magnitude once settled, then held off for four ticks.
   always_comb begin
      mag_hold_count_in = mag_hold_count_ff;
      mag_valid_in      = 1'b0;
      if (mag_hold_count_ff != 3'd0) begin
         mag_hold_count_in = mag_hold_count_ff - 3'd1;
      end else if (!axis_ctrl.settling) begin
         mag_hold_count_in = mocad_pkg::MAG_HOLD_TICKS;
         mag_valid_in      = 1'b1;
      end
   end

   mocad_axis #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_axis_x (
      .sample     (a_x_ff),
      .ctrl       (axis_ctrl),
      .cfg        (cfg_ff),
      .state_cur  (x_state_ff),
      .state_next (x_state_in),
      .result     (x_out)
   );

   mocad_axis #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_axis_y (
      .sample     (a_y_ff),
      .ctrl       (axis_ctrl),
      .cfg        (cfg_ff),
      .state_cur  (y_state_ff),
      .state_next (y_state_in),
      .result     (y_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_count_ff       <= mocad_pkg::SETTLE_TICKS_RST;
         avg_skip_count_ff     <= 8'd0;
         mag_hold_count_ff     <= 3'd0;
         x_state_ff.baseline   <= 16'd0;
         x_state_ff.fast_avg   <= 16'd0;
         x_state_ff.off_count  <= 5'd0;
         x_state_ff.pot        <= mocad_pkg::POT_RST;
         x_state_ff.pot_changed <= 1'b0;
         y_state_ff.baseline   <= 16'd0;
         y_state_ff.fast_avg   <= 16'd0;
         y_state_ff.off_count  <= 5'd0;
         y_state_ff.pot        <= mocad_pkg::POT_RST;
         y_state_ff.pot_changed <= 1'b0;
      end else if (a_fire) begin
         settle_count_ff   <= settle_count_in;
         avg_skip_count_ff <= avg_skip_count_in;
         mag_hold_count_ff <= mag_hold_count_in;
         x_state_ff        <= x_state_in;
         y_state_ff        <= y_state_in;
      end
   end

   // ---------------- stage B: tick results ----------------
   mocad_pkg::axis_out_type b_x_out_ff;
   mocad_pkg::axis_out_type b_y_out_ff;
   logic [7:0]  b_pot_x_ff;
   logic [7:0]  b_pot_y_ff;
   logic        b_mag_valid_ff;
   logic [15:0] b_x_base_ff;
   logic [15:0] b_x_fast_ff;
   logic [15:0] b_y_base_ff;
   logic [15:0] b_y_fast_ff;

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_x_out_ff     <= x_out;
         b_y_out_ff     <= y_out;
         b_pot_x_ff     <= x_state_in.pot;
         b_pot_y_ff     <= y_state_in.pot;
         b_mag_valid_ff <= mag_valid_in;
         b_x_base_ff    <= x_state_in.baseline;
         b_x_fast_ff    <= x_state_in.fast_avg;
         b_y_base_ff    <= y_state_in.baseline;
         b_y_fast_ff    <= y_state_in.fast_avg;
      end
   end

   // ---------------- stage C: magnitude and output register ----------------
   logic [14:0] magnitude;

   mocad_mag u_mag (
      .x_baseline (b_x_base_ff),
      .x_fast_avg (b_x_fast_ff),
      .y_baseline (b_y_base_ff),
      .y_fast_avg (b_y_fast_ff),
      .use_y      (cfg_ff.use_y_in_magnitude),
      .mag_valid  (b_mag_valid_ff),
      .magnitude  (magnitude)
   );

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_pot_x_value     <= b_pot_x_ff;
         rsp_pot_y_value     <= b_pot_y_ff;
         rsp_pot_x_write     <= b_x_out_ff.pot_write;
         rsp_pot_y_write     <= b_y_out_ff.pot_write;
         rsp_scope_x         <= b_x_out_ff.scope;
         rsp_scope_y         <= b_y_out_ff.scope;
         rsp_magnitude       <= magnitude;
         rsp_magnitude_valid <= b_mag_valid_ff;
      end
   end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: magnetometer offset auto-calibration and detect unit
// Drives sample ticks through the valid/stall request channel and tracks the
// calibration state in a local predictor (settle countdown, baselines, fast
// averages, off-range counters, pots, magnitude hold). Every response item is
// checked field by field against the oldest predicted tick report.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 24;
   localparam int PRINT_CAP   = 40;
   localparam int DRAIN_WAIT  = 6;      // margin after the last pending report drains

   // One expected response item
   typedef struct packed {
      logic [7:0]  pot_x;
      logic [7:0]  pot_y;
      logic        pot_x_wr;
      logic        pot_y_wr;
      logic [14:0] scope_x;
      logic [14:0] scope_y;
      logic [14:0] mag;
      logic        mag_valid;
   } tick_report_type;

   // Register image, in csr index order
   typedef struct packed {
      logic [9:0] settle_ticks;
      logic [9:0] busy_level;
      logic [9:0] off_low;
      logic [9:0] off_high;
      logic [9:0] pot_mid;
      logic [3:0] limit;
      logic [7:0] skip;
      logic       use_y;
   } cal_setting_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [9:0]  req_x_sample;
   logic [9:0]  req_y_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_pot_x_value;
   logic [7:0]  rsp_pot_y_value;
   logic        rsp_pot_x_write;
   logic        rsp_pot_y_write;
   logic [14:0] rsp_scope_x;
   logic [14:0] rsp_scope_y;
   logic [14:0] rsp_magnitude;
   logic        rsp_magnitude_valid;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [mocad_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   magnetometer_offset_autocal_detect_unit #(.SAMPLE_BITS(10)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_x_sample        (req_x_sample),
      .req_y_sample        (req_y_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pot_x_value     (rsp_pot_x_value),
      .rsp_pot_y_value     (rsp_pot_y_value),
      .rsp_pot_x_write     (rsp_pot_x_write),
      .rsp_pot_y_write     (rsp_pot_y_write),
      .rsp_scope_x         (rsp_scope_x),
      .rsp_scope_y         (rsp_scope_y),
      .rsp_magnitude       (rsp_magnitude),
      .rsp_magnitude_valid (rsp_magnitude_valid),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // Predictor state. Index 0 is the X axis, 1 is Y.
   // ------------------------------------------------------------------------
   cal_setting_type cur;
   logic [9:0]   settle_cnt;
   logic [15:0]  base_avg  [0:1];
   logic [15:0]  fast_avg  [0:1];
   logic [15:0]  off_cnt   [0:1];
   logic [7:0]   pot       [0:1];
   logic         pot_moved [0:1];
   logic [7:0]   skip_cnt;
   logic [2:0]   hold_cnt;

   tick_report_type due_reports [$];
   int           mismatches;
   int           checked;
   int           cycles;
   bit           idling;   // random gaps/stalls on both channels when set

   // Everything after the baseline update for one axis; returns the pot step flag
   function automatic logic axis_advance(input int a, input logic [9:0] s);
      logic step;
      fast_avg[a] = fast_avg[a] - (fast_avg[a] >> 2);
      fast_avg[a] = fast_avg[a] + {5'd0, s, 1'b0};
      // baseline reload after a pot step; samples below the offset wrap
      if (pot_moved[a])
         base_avg[a] = ({6'd0, s} - mocad_pkg::RELOAD_OFFSET) << 2;
      pot_moved[a] = 1'b0;
      if (s > cur.off_high || s < cur.off_low || settle_cnt > cur.busy_level) begin
         if (off_cnt[a] != 16'hFFFF)
            off_cnt[a] = off_cnt[a] + 16'd1;
      end else begin
         off_cnt[a] = '0;
      end
      step = (off_cnt[a] > {12'd0, cur.limit}) || (settle_cnt != 0 && off_cnt[a] > 16'd1);
      if (step) begin
         // write flag is raised even when the pot is pinned at a rail
         if (s > cur.pot_mid) begin
            if (pot[a] != 8'hFF)
               pot[a] = pot[a] + 8'd1;
         end else begin
            if (pot[a] != 8'h00)
               pot[a] = pot[a] - 8'd1;
         end
         pot_moved[a] = 1'b1;
      end
      return step;
   endfunction

   function automatic void base_track(input int a, input logic [9:0] s);
      base_avg[a] = base_avg[a] - (base_avg[a] >> 5);
      base_avg[a] = base_avg[a] + {9'd0, s[9:3]};
   endfunction

   // |floor((base/4 - fast/8) / 4)| clipped to the deviation limit
   function automatic int clipped_dev(input logic [15:0] b, input logic [15:0] f);
      int d;
      int q;
      d = int'({2'b00, b[15:2]}) - int'({3'b000, f[15:3]});
      q = (d >= 0) ? (d >>> 2) : -(((-d) + 3) >>> 2);
      if (q < 0)
         q = -q;
      if (q > int'(mocad_pkg::DEV_CLIP))
         q = int'(mocad_pkg::DEV_CLIP);
      return q;
   endfunction

   function automatic tick_report_type calibrate_tick(input logic [9:0] xs,
                                                      input logic [9:0] ys);
      tick_report_type r;
      logic gate;
      int   xm;
      int   ym;
      int   sum;
      r = '0;
      if (settle_cnt != 0)
         settle_cnt = settle_cnt - 10'd1;
      gate = (settle_cnt != 0) || (skip_cnt == 0);

      r.scope_x = 15'(int'(mocad_pkg::SCOPE_GAIN) * int'(pot[0]) + int'(xs >> 1));
      if (gate)
         base_track(0, xs);
      r.pot_x_wr = axis_advance(0, xs);

      r.scope_y = 15'(int'(mocad_pkg::SCOPE_GAIN) * int'(pot[1]) + int'(ys >> 1));
      if (gate) begin
         base_track(1, ys);
         skip_cnt = cur.skip;
      end else begin
         skip_cnt = skip_cnt - 8'd1;
      end
      r.pot_y_wr = axis_advance(1, ys);

      // magnitude on every fifth tick once settled, zero otherwise
      if (hold_cnt != 0) begin
         hold_cnt = hold_cnt - 3'd1;
      end else if (settle_cnt == 0) begin
         xm = clipped_dev(base_avg[0], fast_avg[0]);
         ym = cur.use_y ? clipped_dev(base_avg[1], fast_avg[1]) : 0;
         sum = xm * xm + ym * ym;
         r.mag = sum[14:0];
         r.mag_valid = 1'b1;
         hold_cnt = mocad_pkg::MAG_HOLD_TICKS;
      end
      r.pot_x = pot[0];
      r.pot_y = pot[1];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("magnetometer_offset_autocal_detect_unit: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response side: compare accepted items, then pick next stall
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("item %0d %s: got %0d, expected %0d", checked, field, got, want);
   endtask

   always @(posedge clock) begin : rsp_side
      tick_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            report_mismatch("item with nothing pending", 0, 0);
         end else begin
            want = due_reports.pop_front();
            if (rsp_pot_x_value !== want.pot_x)
               report_mismatch("pot_x_value", rsp_pot_x_value, want.pot_x);
            if (rsp_pot_y_value !== want.pot_y)
               report_mismatch("pot_y_value", rsp_pot_y_value, want.pot_y);
            if (rsp_pot_x_write !== want.pot_x_wr)
               report_mismatch("pot_x_write", rsp_pot_x_write, want.pot_x_wr);
            if (rsp_pot_y_write !== want.pot_y_wr)
               report_mismatch("pot_y_write", rsp_pot_y_write, want.pot_y_wr);
            if (rsp_scope_x !== want.scope_x)
               report_mismatch("scope_x", rsp_scope_x, want.scope_x);
            if (rsp_scope_y !== want.scope_y)
               report_mismatch("scope_y", rsp_scope_y, want.scope_y);
            if (rsp_magnitude !== want.mag)
               report_mismatch("magnitude", rsp_magnitude, want.mag);
            if (rsp_magnitude_valid !== want.mag_valid)
               report_mismatch("magnitude_valid", rsp_magnitude_valid, want.mag_valid);
         end
         checked++;
      end
      rsp_stall <= idling && ($urandom_range(99) < IDLE_PCT);
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Valid stays high into the next call; only a gap or wait_idle lowers it.
   task automatic send_tick(input logic [9:0] xs, input logic [9:0] ys);
      while (idling && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= xs;
      req_y_sample <= ys;
      do @(posedge clock); while (req_stall);
      due_reports.push_back(calibrate_tick(xs, ys));
   endtask

   // Stop sending and let every pending item come back
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // All eight registers in csr index order with enable held; enable drops once at the end
   task automatic write_setting(input cal_setting_type s);
      csr_write_en   <= 1'b1;
      csr_index      <= mocad_pkg::CSR_SETTLE_TICKS;
      csr_write_data <= s.settle_ticks;
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_BUSY_SETTLE_LEVEL;
      csr_write_data <= s.busy_level;
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_OFF_LOW;
      csr_write_data <= s.off_low;
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_OFF_HIGH;
      csr_write_data <= s.off_high;
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_POT_MID;
      csr_write_data <= s.pot_mid;
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_OFF_RANGE_LIMIT;
      csr_write_data <= 10'(s.limit);
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_AVG_SKIP_INTERVAL;
      csr_write_data <= 10'(s.skip);
      @(posedge clock);
      csr_index      <= mocad_pkg::CSR_USE_Y_IN_MAGNITUDE;
      csr_write_data <= 10'(s.use_y);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      // settle_ticks is kept but the running countdown is not reloaded
      cur = s;
   endtask

   function automatic cal_setting_type make_setting(
      input int st, input int busy, input int lo, input int hi,
      input int mid, input int lim, input int skip, input int use_y);
      cal_setting_type s;
      s.settle_ticks = 10'(st);
      s.busy_level   = 10'(busy);
      s.off_low      = 10'(lo);
      s.off_high     = 10'(hi);
      s.pot_mid      = 10'(mid);
      s.limit        = 4'(lim);
      s.skip         = 8'(skip);
      s.use_y        = 1'(use_y);
      return s;
   endfunction

   function automatic logic [9:0] near_level(input int lvl);
      int v;
      v = lvl + $urandom_range(16) - 8;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return 10'(v);
   endfunction

   // Slowly varying field with steps, pulses and a sprinkle of raw noise
   task automatic send_track(input int n);
      int lx;
      int ly;
      int r;
      int k;
      lx = $urandom_range(750, 250);
      ly = $urandom_range(750, 250);
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 3)
            lx = $urandom_range(1023);
         else if (r < 6)
            ly = $urandom_range(1023);
         else if (r < 9)
            lx = $urandom_range(750, 250);
         if (r >= 94)
            send_tick(10'($urandom), 10'($urandom));
         else
            send_tick(near_level(lx), near_level(ly));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset defaults, still busy settling: every tick is off range, pots step
   // from the second tick and reloads see samples below the reload offset.
   task automatic test_extremes;
      send_tick(10'd0,    10'd0);
      send_tick(10'd1023, 10'd1023);
      send_tick(10'd0,    10'd1023);
      send_tick(10'd1023, 10'd0);
      send_tick(10'd299,  10'd701);
      send_tick(10'd300,  10'd700);
      send_tick(10'd701,  10'd299);
      send_tick(10'd500,  10'd501);
      send_tick(10'd501,  10'd500);
      send_tick(10'd1,    10'd1);
      send_tick(10'd234,  10'd235);
      send_tick(10'd235,  10'd234);
      send_tick(10'h2AA,  10'h155);
      send_tick(10'h155,  10'h2AA);
      send_tick(10'd0,    10'd0);
      send_tick(10'd512,  10'd511);
      send_tick(10'd511,  10'd512);
      send_tick(10'd1022, 10'd2);
      send_tick(10'd700,  10'd300);
      send_tick(10'd0,    10'd1023);
      send_tick(10'd236,  10'd0);
      send_tick(10'd1023, 10'd1023);
      send_tick(10'd400,  10'd600);
      send_tick(10'd0,    10'd0);
   endtask

   // Busy level moved while the settle countdown still runs
   task automatic test_settle_window;
      wait_idle();
      write_setting(make_setting(1023, 1023, 0, 1023, 500, 15, 0, 1));
      send_track(30);
      wait_idle();
      write_setting(make_setting(0, 0, 300, 700, 500, 1, 7, 0));
      send_track(30);
   endtask

   // Window turned inside out so every sample is off range: pots run into
   // both rails and the write flag keeps firing there.
   task automatic test_pot_rails;
      int k;
      wait_idle();
      write_setting(make_setting(160, 100, 1023, 0, 0, 0, 0, 1));
      for (k = 0; k < 160; k++)
         send_tick(10'($urandom), 10'($urandom));
      wait_idle();
      write_setting(make_setting(160, 100, 1023, 0, 1023, 0, 255, 0));
      for (k = 0; k < 300; k++)
         send_tick(10'($urandom), 10'($urandom));
   endtask

   // Settled tracking under several settings, magnitudes flowing
   task automatic test_tracking;
      int ph;
      // no gaps or stalls for this stretch
      wait_idle();
      idling = 1'b0;
      write_setting(make_setting(160, 100, 300, 700, 500, 1, 3, 1));
      send_track(210);
      wait_idle();
      idling = 1'b1;
      write_setting(make_setting(1023, 0, 0, 1023, 1023, 15, 255, 1));
      send_track(210);
      wait_idle();
      write_setting(make_setting(0, 1023, 480, 520, 500, 0, 0, 0));
      send_track(210);
      for (ph = 0; ph < 2; ph++) begin
         wait_idle();
         write_setting(make_setting($urandom_range(1023), $urandom_range(1023),
                                    $urandom_range(400), $urandom_range(1023, 600),
                                    $urandom_range(1023), $urandom_range(15),
                                    $urandom_range(255), $urandom_range(1)));
         send_track(210);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_x_sample   <= '0;
      req_y_sample   <= '0;
      rsp_stall      <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_index      <= mocad_pkg::CSR_SETTLE_TICKS;
      csr_write_data <= '0;
      cycles         <= 0;
      mismatches     = 0;
      checked        = 0;
      idling         = 1'b1;

      cur = make_setting(mocad_pkg::SETTLE_TICKS_RST, mocad_pkg::BUSY_SETTLE_LEVEL_RST,
                         mocad_pkg::OFF_LOW_RST, mocad_pkg::OFF_HIGH_RST,
                         mocad_pkg::POT_MID_RST, mocad_pkg::OFF_RANGE_LIMIT_RST,
                         mocad_pkg::AVG_SKIP_INTERVAL_RST, mocad_pkg::USE_Y_RST);
      settle_cnt   = mocad_pkg::SETTLE_TICKS_RST;
      base_avg[0]  = '0;
      base_avg[1]  = '0;
      fast_avg[0]  = '0;
      fast_avg[1]  = '0;
      off_cnt[0]   = '0;
      off_cnt[1]   = '0;
      pot[0]       = mocad_pkg::POT_RST;
      pot[1]       = mocad_pkg::POT_RST;
      pot_moved[0] = 1'b0;
      pot_moved[1] = 1'b0;
      skip_cnt     = '0;
      hold_cnt     = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_settle_window();
      test_pot_rails();
      test_tracking();

      wait_idle();
      if (mismatches == 0)
         $display("magnetometer_offset_autocal_detect_unit: match");
      else
         $display("magnetometer_offset_autocal_detect_unit: mismatch");
      $finish;
   end

endmodule

@@ magnetometer_offset_autocal_detect_unit.f @@
rtl/mocad_pkg.sv
rtl/mocad_axis.sv
rtl/mocad_mag.sv
rtl/magnetometer_offset_autocal_detect_unit.sv
bench/tb.sv
